FILE: rtl/dsq_pkg.sv
package dsq_pkg;

  localparam int unsigned SEMIS = 12;
  localparam int unsigned STEPS = 7;
  localparam int unsigned N_SNAP = 5;

  // Configuration register indexes (APB word address).
  localparam logic REG_TONIC = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  // Function codes of an input beat.
  typedef enum logic {
    FUNC_SNAP   = 1'b0,
    FUNC_DEGREE = 1'b1
  } func_e;

  localparam logic [3:0] ION_PATTERN [STEPS] = '{
    4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
  };

  localparam logic signed [5:0] SNAP_OFFSETS [N_SNAP] = '{
    6'sd0, 6'sd1, -6'sd1, 6'sd2, -6'sd2
  };

  // Payload passed from the snap half to the arithmetic half.
  typedef struct packed {
    logic [7:0]        divd;     // biased diatonic index, divided by seven next
    logic signed [4:0] base;     // octave offset added to the quotient
    logic              inscale;
  } front_t;

  // Tonic codes twelve to fifteen fold back by one octave.
  function automatic logic [3:0] eff_tonic(input logic [3:0] raw);
    eff_tonic = (raw >= 4'd12) ? raw - 4'd12 : raw;
  endfunction

  // Mode code seven behaves as ionian.
  function automatic logic [2:0] eff_mode(input logic [2:0] raw);
    eff_mode = (raw == 3'd7) ? 3'd0 : raw;
  endfunction

  // Semitones of scale index i above the tonic for mode m.
  function automatic logic [3:0] interval_of(input logic [2:0] m, input logic [2:0] i);
    logic [3:0] j;
    logic [4:0] diff;
    j = {1'b0, m} + {1'b0, i};
    if (j >= 4'd7) begin
      j = j - 4'd7;
    end
    diff = {1'b0, ION_PATTERN[j[2:0]]} - {1'b0, ION_PATTERN[m]};
    if (diff[4]) begin
      diff = diff + 5'd12;
    end
    interval_of = diff[3:0];
  endfunction

  // Pitch classes, relative to the tonic, that belong to mode m.
  function automatic logic [SEMIS-1:0] scale_mask(input logic [2:0] m);
    logic [SEMIS-1:0] mask;
    mask = '0;
    for (int i = 0; i < STEPS; i++) begin
      mask[interval_of(m, 3'(i))] = 1'b1;
    end
    scale_mask = mask;
  endfunction

  // Scale index of a relative pitch class that is a member of mode m.
  function automatic logic [2:0] index_of(input logic [2:0] m, input logic [3:0] pc);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (interval_of(m, 3'(i)) == pc) begin
        idx = 3'(i);
      end
    end
    index_of = idx;
  endfunction

endpackage

FILE: rtl/dsq_if.sv
interface dsq_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [6:0]        pitch;
  logic signed [5:0] steps;
  logic [6:0]        degree;
  logic signed [4:0] octave;

  modport source (output valid, func, pitch, steps, degree, octave, input ready);
  modport sink   (input valid, func, pitch, steps, degree, octave, output ready);
endinterface

interface dsq_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] result_pitch;
  logic [2:0]        result_degree;
  logic              input_in_scale;

  modport source (output valid, result_pitch, result_degree, input_in_scale, input ready);
  modport sink   (input valid, result_pitch, result_degree, input_in_scale, output ready);
endinterface

FILE: rtl/dsq_cfg.sv
module dsq_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  tonic_o,
  output logic [2:0]  mode_o
);
  import dsq_pkg::*;

  logic [3:0] tonic_q, tonic_d;
  logic [2:0] mode_q, mode_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    tonic_d = tonic_q;
    mode_d  = mode_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_TONIC: tonic_d = pwdata[3:0];
        REG_MODE:  mode_d  = pwdata[2:0];
        default:   tonic_d = tonic_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TONIC: prdata = {28'd0, tonic_q};
      REG_MODE:  prdata = {29'd0, mode_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tonic_q <= '0;
      mode_q  <= '0;
    end else begin
      tonic_q <= tonic_d;
      mode_q  <= mode_d;
    end
  end

  assign tonic_o = tonic_q;
  assign mode_o  = mode_q;

endmodule

FILE: rtl/dsq_front.sv
module dsq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         tonic_i,
  input  logic [2:0]         mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [6:0]         pitch_i,
  input  logic signed [5:0]  steps_i,
  input  logic [6:0]         degree_i,
  input  logic signed [4:0]  octave_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dsq_pkg::front_t    out_data_o
);
  import dsq_pkg::*;

  typedef struct packed {
    logic              func;
    logic [3:0]        relpc;   // pitch class above the tonic
    logic signed [4:0] oct;     // octave above the tonic
    logic signed [5:0] steps;
    logic [6:0]        degree;
    logic signed [4:0] octave;
  } stage_a_t;

  logic [3:0]  tonic;
  logic [2:0]  mode;

  // Stage A: split pitch minus tonic into octave and pitch class.
  logic        a_valid_q;
  logic        a_ready;
  stage_a_t    a_q, a_d;
  logic [7:0]  a_rel;
  logic [15:0] a_prod;
  logic [3:0]  a_quot;
  logic [7:0]  a_rem;

  // Stage B: snap, then fold in the scale steps, or pass a degree request on.
  logic             b_valid_q;
  logic             b_ready;
  front_t           b_q, b_d;
  logic [SEMIS-1:0] mask;
  logic             found;
  logic signed [5:0] cand;
  logic signed [4:0] cand_oct;
  logic [3:0]       snap_pc;
  logic signed [4:0] snap_oct;
  logic [2:0]       snap_idx;
  logic signed [8:0] biased;

  assign tonic = eff_tonic(tonic_i);
  assign mode  = eff_mode(mode_i);

  assign b_ready    = ~b_valid_q | out_ready_i;
  assign a_ready    = ~a_valid_q | b_ready;
  assign in_ready_o = a_ready;

  // Offset by one octave so the value stays positive; 171/2048 stands in
  // for 1/12 exactly over the range below 192.
  assign a_rel  = {1'b0, pitch_i} + 8'd12 - {4'd0, tonic};
  assign a_prod = 16'(a_rel) * 16'd171;
  assign a_quot = a_prod[14:11];
  assign a_rem  = a_rel - 8'(a_quot) * 8'd12;

  always_comb begin
    a_d.func   = func_i;
    a_d.relpc  = a_rem[3:0];
    a_d.oct    = $signed({1'b0, a_quot}) - 5'sd1;
    a_d.steps  = steps_i;
    a_d.degree = degree_i;
    a_d.octave = octave_i;
  end

  always_comb begin
    mask     = scale_mask(mode);
    found    = 1'b0;
    snap_pc  = a_q.relpc;
    snap_oct = a_q.oct;
    cand     = '0;
    cand_oct = '0;
    // Offsets are tried in priority order; the first member wins.
    for (int k = 0; k < N_SNAP; k++) begin
      cand     = $signed({2'b00, a_q.relpc}) + SNAP_OFFSETS[k];
      cand_oct = a_q.oct;
      if (cand < 6'sd0) begin
        cand     = cand + 6'sd12;
        cand_oct = cand_oct - 5'sd1;
      end else if (cand >= 6'sd12) begin
        cand     = cand - 6'sd12;
        cand_oct = cand_oct + 5'sd1;
      end
      if (!found && mask[cand[3:0]]) begin
        found    = 1'b1;
        snap_pc  = cand[3:0];
        snap_oct = cand_oct;
      end
    end
    snap_idx = index_of(mode, snap_pc);
    // Diatonic index plus seven octaves of bias, always positive.
    biased = ($signed({{4{snap_oct[4]}}, snap_oct}) * 9'sd7)
           + $signed({6'd0, snap_idx})
           + $signed({{3{a_q.steps[5]}}, a_q.steps})
           + 9'sd49;

    if (a_q.func == FUNC_DEGREE) begin
      b_d.divd    = {1'b0, a_q.degree} + 8'd6;
      b_d.base    = a_q.octave;
      b_d.inscale = 1'b0;
    end else begin
      b_d.divd    = biased[7:0];
      b_d.base    = -5'sd7;
      b_d.inscale = mask[a_q.relpc];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q <= a_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_q;

endmodule

FILE: rtl/dsq_back.sv
module dsq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         tonic_i,
  input  logic [2:0]         mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dsq_pkg::front_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [8:0]  result_pitch_o,
  output logic [2:0]         result_degree_o,
  output logic               input_in_scale_o
);
  import dsq_pkg::*;

  typedef struct packed {
    logic signed [4:0] base;
    logic [4:0]        quot;
    logic [2:0]        rem;
    logic              inscale;
  } stage_c_t;

  typedef struct packed {
    logic signed [8:0] pitch;
    logic [2:0]        degree;
    logic              inscale;
  } stage_d_t;

  logic [3:0]  tonic;
  logic [2:0]  mode;

  logic        c_valid_q;
  logic        c_ready;
  stage_c_t    c_q, c_d;
  logic [15:0] c_prod;
  logic [7:0]  c_rem;

  logic              d_valid_q;
  logic              d_ready;
  stage_d_t          d_q, d_d;
  logic signed [6:0] d_oct;
  logic signed [10:0] d_pitch;

  assign tonic = eff_tonic(tonic_i);
  assign mode  = eff_mode(mode_i);

  assign d_ready    = ~d_valid_q | out_ready_i;
  assign c_ready    = ~c_valid_q | d_ready;
  assign in_ready_o = c_ready;

  // Division by seven: 147/1024 is exact for dividends below 204.
  assign c_prod = 16'(in_data_i.divd) * 16'd147;
  assign c_rem  = in_data_i.divd - 8'(c_prod[14:10]) * 8'd7;

  always_comb begin
    c_d.base    = in_data_i.base;
    c_d.quot    = c_prod[14:10];
    c_d.rem     = c_rem[2:0];
    c_d.inscale = in_data_i.inscale;
  end

  always_comb begin
    d_oct   = $signed({{2{c_q.base[4]}}, c_q.base}) + $signed({2'b00, c_q.quot});
    d_pitch = ($signed({{4{d_oct[6]}}, d_oct}) * 11'sd12)
            + $signed({7'd0, tonic})
            + $signed({7'd0, interval_of(mode, c_q.rem)});
    d_d.pitch   = d_pitch[8:0];
    d_d.degree  = c_q.rem + 3'd1;
    d_d.inscale = c_q.inscale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_q <= c_d;
    end
    if (d_ready && c_valid_q) begin
      d_q <= d_d;
    end
  end

  assign out_valid_o      = d_valid_q;
  assign result_pitch_o   = d_q.pitch;
  assign result_degree_o  = d_q.degree;
  assign input_in_scale_o = d_q.inscale;

  // The biased dividend never leaves the range where the reciprocal is exact.
  a_divd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (in_data_i.divd >= 8'd3) && (in_data_i.divd <= 8'd163))
    else $error("dividend outside the exact reciprocal range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> c_q.rem != 3'd7)
    else $error("remainder by seven out of range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> c_q.quot <= 5'd23)
    else $error("quotient by seven out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && !d_ready) |=> c_valid_q && $stable(c_q))
    else $error("stage C lost or changed its beat under a stall");

endmodule

FILE: rtl/diatonic_scale_quantizer_unit.sv
// Path: a beat accepted into stage A moves on through stages B and C into stage D, the
// output register. Throughput: one beat per cycle while the output accepts results;
// each of the four register stages has a valid bit and stalls only while it holds a
// beat that the next stage cannot take.
// Reset (rst_ni low, asynchronous): all valid bits clear, so the pipeline is empty,
// and the tonic and mode registers return to C ionian.
module diatonic_scale_quantizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsq_in_if.sink      in_i,
  dsq_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dsq_pkg::*;

  // Raw register contents; the stages fold out-of-range codes themselves.
  logic [3:0] tonic;
  logic [2:0] mode;

  // Beat between the snap half and the arithmetic half of the pipeline.
  logic       mid_valid;
  logic       mid_ready;
  front_t     mid_data;

  // The user must write the configuration registers over APB only while the pipeline is empty;
  // the block does not enforce it. Every stage then reads them directly, without a copy per beat.
  dsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tonic_o (tonic),
    .mode_o  (mode)
  );

  // Stages A and B: the pitch is split into octave and pitch class above the
  // tonic, snapped onto the scale and turned into a biased diatonic index.
  // Degree requests are routed through the same beat format, so that both
  // functions share the division and the pitch build that follow.
  dsq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tonic_i     (tonic),
    .mode_i      (mode),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .func_i      (in_i.func),
    .pitch_i     (in_i.pitch),
    .steps_i     (in_i.steps),
    .degree_i    (in_i.degree),
    .octave_i    (in_i.octave),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  // Stages C and D: division by seven into octave and scale index, then the
  // final pitch from octave, tonic and the mode's interval. Stage D is the
  // output register.
  dsq_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tonic_i          (tonic),
    .mode_i           (mode),
    .in_valid_i       (mid_valid),
    .in_ready_o       (mid_ready),
    .in_data_i        (mid_data),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .result_pitch_o   (out_o.result_pitch),
    .result_degree_o  (out_o.result_degree),
    .input_in_scale_o (out_o.input_in_scale)
  );

endmodule

FILE: dv/tb_top.sv
import dsq_pkg::*;

// Semitone pattern of the major scale and the order in which the snap tries its offsets.
localparam int MAJOR_STEPS [7] = '{0, 2, 4, 5, 7, 9, 11};
localparam int SNAP_TRIES [5] = '{0, 1, -1, 2, -2};

typedef struct packed {
  logic signed [8:0] pitch;
  logic [2:0]        degree;
  logic              in_scale;
} quantized_note_t;

// Keeps its own copy of the tonic and mode, works out the note that each accepted input
// beat should produce, and compares result beats with those notes in order.
class pitch_scoreboard;
  int              tonic_pc;
  int              mode_idx;
  int              errors;
  quantized_note_t expected_notes[$];

  function new();
    tonic_pc = 0;
    mode_idx = 0;
    errors   = 0;
  endfunction

  function void set_register(logic reg_sel, int value);
    if (reg_sel == REG_TONIC) begin
      tonic_pc = value & 15;
      if (tonic_pc >= 12) begin
        tonic_pc = tonic_pc - 12;
      end
    end else begin
      mode_idx = value & 7;
      if (mode_idx == 7) begin
        mode_idx = 0;
      end
    end
  endfunction

  function int floor_div(int a, int b);
    return (a >= 0) ? a / b : -((-a + b - 1) / b);
  endfunction

  function int floor_mod(int a, int b);
    return a - floor_div(a, b) * b;
  endfunction

  // Semitones of scale index i above the tonic in the current mode.
  function int semis_above_tonic(int i);
    return floor_mod(MAJOR_STEPS[(mode_idx + i) % 7] - MAJOR_STEPS[mode_idx], 12);
  endfunction

  // Scale index of the pitch, or 7 when its pitch class is not in the scale.
  function int scale_index(int p);
    int rel_pc;
    int idx;
    rel_pc = floor_mod(p - tonic_pc, 12);
    idx = 7;
    for (int i = 6; i >= 0; i--) begin
      if (semis_above_tonic(i) == rel_pc) begin
        idx = i;
      end
    end
    return idx;
  endfunction

  function quantized_note_t quantize(func_e func, logic [6:0] pitch, logic signed [5:0] steps,
                                     logic [6:0] degree, logic signed [4:0] octave);
    quantized_note_t r;
    int p;
    int step;
    int idx;
    int res;
    int deg;
    int d;
    bit found;
    r.in_scale = 1'b0;
    if (func == FUNC_SNAP) begin
      p = int'(pitch);
      found = 1'b0;
      for (int k = 0; k < 5; k++) begin
        if (!found && scale_index(int'(pitch) + SNAP_TRIES[k]) < 7) begin
          p = int'(pitch) + SNAP_TRIES[k];
          found = 1'b1;
        end
      end
      r.in_scale = (scale_index(int'(pitch)) < 7);
      step = scale_index(p);
      if (step >= 7) begin
        res = p;
        deg = 0;
      end else begin
        idx  = floor_div(p - tonic_pc - semis_above_tonic(step), 12) * 7 + step + int'(steps);
        step = floor_mod(idx, 7);
        res  = floor_div(idx, 7) * 12 + semis_above_tonic(step) + tonic_pc;
        deg  = step + 1;
      end
    end else begin
      d    = int'(degree) - 1;
      step = floor_mod(d, 7);
      res  = (int'(octave) + 1 + floor_div(d, 7)) * 12 + tonic_pc + semis_above_tonic(step);
      deg  = step + 1;
    end
    r.pitch  = 9'(res);
    r.degree = 3'(deg);
    return r;
  endfunction

  function void note_input(func_e func, logic [6:0] pitch, logic signed [5:0] steps,
                           logic [6:0] degree, logic signed [4:0] octave);
    expected_notes.push_back(quantize(func, pitch, steps, degree, octave));
  endfunction

  function void check_result(quantized_note_t got);
    quantized_note_t want;
    if (expected_notes.size() == 0) begin
      $display("%0t: result beat with nothing expected: pitch %0d degree %0d in_scale %0d",
               $time, got.pitch, got.degree, got.in_scale);
      errors++;
      return;
    end
    want = expected_notes.pop_front();
    if (got.pitch !== want.pitch) begin
      $display("%0t: result_pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
      errors++;
    end
    if (got.degree !== want.degree) begin
      $display("%0t: result_degree expected %0d actual %0d", $time, want.degree, got.degree);
      errors++;
    end
    if (got.in_scale !== want.in_scale) begin
      $display("%0t: input_in_scale expected %0d actual %0d", $time, want.in_scale,
               got.in_scale);
      errors++;
    end
  endfunction

  function int pending();
    return expected_notes.size();
  endfunction
endclass

module tb_top;

  // No beat may be accepted on either side for this many cycles in a row. The longest
  // legitimate quiet spell is a random idle burst plus the four-stage pipeline and a pair of
  // register writes, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 2000;
  // Number of random phases; each one runs under its own tonic and mode.
  localparam int N_PHASES = 13;
  localparam int PHASE_BEATS = 150;
  // Phases from this one onwards run with neither side idling.
  localparam int STEADY_PHASE = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit idle_enabled = 1'b1;

  pitch_scoreboard sb = new();

  dsq_in_if  in_bus ();
  dsq_out_if out_bus ();

  diatonic_scale_quantizer_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // One register write: a setup cycle, then an access cycle that completes at the edge
  // where pready is seen high. psel is left high so that a second write can follow at
  // once; configure drops it afterwards.
  task automatic write_reg(logic reg_sel, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    sb.set_register(reg_sel, value);
  endtask

  // Sets tonic and mode. Only ever called while the pipeline is empty.
  task automatic configure(int tonic_code, int mode_code);
    write_reg(REG_TONIC, tonic_code);
    write_reg(REG_MODE, mode_code);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Presents one input beat and returns at the edge where it is accepted. While idling
  // is enabled, a random burst of empty cycles may come first. The beat is handed to
  // the scoreboard exactly as it went onto the bus.
  task automatic send_note(func_e func, int pitch, int steps, int degree, int octave);
    logic [6:0]        p;
    logic signed [5:0] s;
    logic [6:0]        d;
    logic signed [4:0] o;
    int                gap;
    p = 7'(pitch);
    s = 6'(steps);
    d = 7'(degree);
    o = 5'(octave);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.func   <= func;
    in_bus.pitch  <= p;
    in_bus.steps  <= s;
    in_bus.degree <= d;
    in_bus.octave <= o;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    sb.note_input(func, p, s, d, o);
  endtask

  // Random beat. Most fields stay inside their musical ranges, but in about one beat in
  // eight each of steps, degree and octave uses its whole width, so that the wrapping and
  // degree-zero corners are reached as well.
  task automatic send_random_note();
    func_e func;
    int    steps;
    int    degree;
    int    octave;
    func = ($urandom_range(0, 1) == 1) ? FUNC_DEGREE : FUNC_SNAP;
    if ($urandom_range(0, 7) == 0) begin
      steps = int'($urandom_range(0, 63)) - 32;
    end else begin
      steps = int'($urandom_range(0, 48)) - 24;
    end
    if ($urandom_range(0, 7) == 0) begin
      degree = $urandom_range(0, 127);
    end else begin
      degree = $urandom_range(1, 64);
    end
    if ($urandom_range(0, 7) == 0) begin
      octave = int'($urandom_range(0, 31)) - 16;
    end else begin
      octave = int'($urandom_range(0, 10)) - 1;
    end
    send_note(func, $urandom_range(0, 127), steps, degree, octave);
  endtask

  // Stops sending and waits until every expected result beat has come back. After this
  // the pipeline is empty, since each input beat yields exactly one result beat.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Result side. Every accepted result beat is checked against the oldest expected note.
  // The ready line idles in random bursts unless idling is switched off.
  initial begin
    quantized_note_t got;
    int              stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    forever begin
      if (out_bus.valid && out_bus.ready) begin
        got.pitch    = out_bus.result_pitch;
        got.degree   = out_bus.result_degree;
        got.in_scale = out_bus.input_in_scale;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  // Watchdog: counts consecutive cycles in which no beat is accepted on either side.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top failed");
    $finish;
  end

  // Main sequence: reset, a directed part under a few hand-picked settings, then random
  // phases, each under a fresh tonic and mode. Between phases the sender waits until the
  // pipeline has emptied, and only then are the registers rewritten.
  initial begin
    int tonic_code;
    int mode_code;

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_bus.valid  <= 1'b0;
    in_bus.func   <= FUNC_SNAP;
    in_bus.pitch  <= '0;
    in_bus.steps  <= '0;
    in_bus.degree <= '0;
    in_bus.octave <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // C ionian: extremes of pitch and steps, an off-scale pitch that must snap, a zero
    // step, and degree lookups at both ends, degree zero and a result that wraps.
    configure(0, 0);
    send_note(FUNC_SNAP, 0, 0, 1, 4);
    send_note(FUNC_SNAP, 127, 31, 64, 9);
    send_note(FUNC_SNAP, 127, -32, 0, -1);
    send_note(FUNC_SNAP, 0, -32, 127, 15);
    send_note(FUNC_SNAP, 1, -24, 1, -16);
    send_note(FUNC_SNAP, 6, 24, 5, 0);
    send_note(FUNC_SNAP, 61, 1, 3, 2);
    send_note(FUNC_DEGREE, 0, 0, 0, -16);
    send_note(FUNC_DEGREE, 127, 31, 127, 15);
    send_note(FUNC_DEGREE, 0, 0, 1, -1);
    send_note(FUNC_DEGREE, 64, -1, 64, 9);
    send_note(FUNC_DEGREE, 60, 0, 7, 4);
    drain();

    // Tonic code fifteen folds to E flat, and mode code seven behaves as ionian.
    configure(15, 7);
    send_note(FUNC_SNAP, 64, 0, 1, 4);
    send_note(FUNC_SNAP, 4, -1, 1, 4);
    send_note(FUNC_DEGREE, 0, 0, 0, -1);
    send_note(FUNC_SNAP, 126, 24, 1, 4);
    drain();

    // Highest real tonic with the highest mode: B locrian.
    configure(11, 6);
    send_note(FUNC_SNAP, 127, -24, 1, 4);
    send_note(FUNC_SNAP, 0, 5, 1, 4);
    send_note(FUNC_DEGREE, 0, 0, 127, -16);
    send_note(FUNC_DEGREE, 0, 0, 8, 0);
    drain();

    // Tonic code twelve folds back to C; lydian moves the fourth degree up.
    configure(12, 3);
    send_note(FUNC_SNAP, 5, 0, 1, 4);
    send_note(FUNC_DEGREE, 0, 0, 4, 4);
    send_note(FUNC_SNAP, 66, -7, 1, 4);
    drain();

    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase == STEADY_PHASE) begin
        idle_enabled = 1'b0;
      end
      case (phase)
        0: begin
          tonic_code = 0;
          mode_code  = 0;
        end
        1: begin
          tonic_code = 15;
          mode_code  = 7;
        end
        2: begin
          tonic_code = 11;
          mode_code  = 6;
        end
        default: begin
          tonic_code = $urandom_range(0, 15);
          mode_code  = $urandom_range(0, 7);
        end
      endcase
      configure(tonic_code, mode_code);
      repeat (PHASE_BEATS) send_random_note();
      drain();
    end

    // Every result is in; give the four-stage pipeline time to show any stray beat.
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
